@@ design/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and the arctangent step table for the quaternion
// to Euler angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

  // Port and datapath widths.
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;
  localparam int PROD_W   = 32;
  localparam int SUM_W    = 34;
  localparam int CORDIC_W = 37;
  localparam int ANG_W    = 32;
  localparam int ROOT_W   = 29;
  localparam int RAD_W    = 57;

  // Rotation step table length and default step count.
  localparam int ATAN_LEN           = 24;
  localparam int ANGLE_ITER_DEFAULT = 16;

  // Angle constants in 32-bit binary angle units (2^31 is pi).
  localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [ANG_W-1:0] ROUND_HALF   = 32'h0000_8000;

  // One in the Q.28 format of the pitch sine term.
  localparam logic signed [SUM_W-1:0] UNIT_Q28 = 34'sd268435456;

  // Rounded atan(2^-i) in binary angle units.
  function automatic logic [ANG_W-1:0] atan_step(input int idx);
    logic [ANG_W-1:0] val;
    case (idx)
      0:  val = 32'd536870912;
      1:  val = 32'd316933406;
      2:  val = 32'd167458907;
      3:  val = 32'd85004756;
      4:  val = 32'd42667331;
      5:  val = 32'd21354465;
      6:  val = 32'd10679838;
      7:  val = 32'd5340245;
      8:  val = 32'd2670163;
      9:  val = 32'd1335087;
      10: val = 32'd667544;
      11: val = 32'd333772;
      12: val = 32'd166886;
      13: val = 32'd83443;
      14: val = 32'd41722;
      15: val = 32'd20861;
      16: val = 32'd10430;
      17: val = 32'd5215;
      18: val = 32'd2608;
      19: val = 32'd1304;
      20: val = 32'd652;
      21: val = 32'd326;
      22: val = 32'd163;
      23: val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ design/qte_sqrt.sv @@
// ----------------------------------------------------------------------------
// qte_sqrt
// Pipelined floor square root, one result bit decided per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_sqrt
  import qte_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [RAD_W-1:0]  in_radicand,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      out_root
);

  localparam int TW = RAD_W + 2;

  // Stage 0 holds the radicand; stage i+1 has decided root bit ROOT_W-1-i.
  logic [RAD_W-1:0]  rem_r [0:ROOT_W];
  logic [ROOT_W-1:0] q_r   [0:ROOT_W];
  logic              vld_r [0:ROOT_W];

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    rem_r[0] <= in_radicand;
    q_r[0]   <= '0;
  end

  // Trial subtraction stages: remainder always equals radicand minus root squared.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int K = ROOT_W - 1 - i;
    logic [TW-1:0] trial;
    logic          take;

    assign trial = (TW'(q_r[i]) << (K + 1)) + (TW'(1) << (2 * K));
    assign take  = TW'(rem_r[i]) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      if (take) begin
        rem_r[i+1] <= RAD_W'(TW'(rem_r[i]) - trial);
        q_r[i+1]   <= q_r[i] | (ROOT_W'(1) << K);
      end else begin
        rem_r[i+1] <= rem_r[i];
        q_r[i+1]   <= q_r[i];
      end
    end
  end

  assign out_valid = vld_r[ROOT_W];
  assign out_root  = q_r[ROOT_W];

endmodule

`default_nettype wire

@@ design/qte_cordic.sv @@
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined CORDIC vectoring unit giving atan2(y, x) as a 32-bit binary angle.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic
  import qte_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic signed [CORDIC_W-1:0] in_x,
  input  wire logic signed [CORDIC_W-1:0] in_y,
  output logic                            out_valid,
  output logic [ANG_W-1:0]                out_angle
);

  logic signed [CORDIC_W-1:0] x_r    [0:ANGLE_ITERATIONS];
  logic signed [CORDIC_W-1:0] y_r    [0:ANGLE_ITERATIONS];
  logic [ANG_W-1:0]           ang_r  [0:ANGLE_ITERATIONS];
  logic                       zero_r [0:ANGLE_ITERATIONS];
  logic                       vld_r  [0:ANGLE_ITERATIONS];

  // Entry stage: fold the left half plane into the right by a quarter turn.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    zero_r[0] <= (in_x == '0) && (in_y == '0);
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x_r[0]   <= in_y;
        y_r[0]   <= -in_x;
        ang_r[0] <= QUARTER_TURN;
      end else begin
        x_r[0]   <= -in_y;
        y_r[0]   <= in_x;
        ang_r[0] <= -QUARTER_TURN;
      end
    end else begin
      x_r[0]   <= in_x;
      y_r[0]   <= in_y;
      ang_r[0] <= '0;
    end
  end

  // Micro-rotation stages, each driving y toward zero.
  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_rot
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      zero_r[i+1] <= zero_r[i];
      if (y_r[i] >= 0) begin
        x_r[i+1]   <= x_r[i] + dx;
        y_r[i+1]   <= y_r[i] - dy;
        ang_r[i+1] <= ang_r[i] + atan_step(i);
      end else begin
        x_r[i+1]   <= x_r[i] - dx;
        y_r[i+1]   <= y_r[i] + dy;
        ang_r[i+1] <= ang_r[i] - atan_step(i);
      end
    end
  end

  // A zero vector reports angle zero.
  assign out_valid = vld_r[ANGLE_ITERATIONS];
  assign out_angle = zero_r[ANGLE_ITERATIONS] ? '0 : ang_r[ANGLE_ITERATIONS];

endmodule

`default_nettype wire

@@ design/quaternion_to_euler_angles.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a Q2.14 attitude quaternion into roll, pitch and yaw angles.
// ----------------------------------------------------------------------------
// The block accepts one quaternion in every clock cycle (busy is always low)
// and returns its angles, marked by out_valid for one cycle, after start has
// passed the input register, the product, sum and sine magnitude registers,
// the bit-per-stage square root for the pitch cosine, the CORDIC stages and
// one output register.
// Results cannot be held off, so the receiver must take each one as it comes.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles
  import qte_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [IN_W-1:0]  in_quat_w,
  input  wire logic signed [IN_W-1:0]  in_quat_x,
  input  wire logic signed [IN_W-1:0]  in_quat_y,
  input  wire logic signed [IN_W-1:0]  in_quat_z,
  output logic                         out_valid,
  output logic signed [OUT_W-1:0]      out_roll_angle,
  output logic signed [OUT_W-1:0]      out_pitch_angle,
  output logic signed [OUT_W-1:0]      out_yaw_angle,
  output logic                         out_pitch_clamped
);

  localparam int SIDE_LEN = ROOT_W + 2;

  typedef struct packed {
    logic signed [SUM_W-1:0] roll_y;
    logic signed [SUM_W-1:0] roll_x;
    logic signed [SUM_W-1:0] yaw_y;
    logic signed [SUM_W-1:0] yaw_x;
    logic signed [SUM_W-1:0] sin_p;
  } side_t;

  typedef struct packed {
    logic clamp_pos;
    logic clamp_neg;
  } clamp_t;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Stage 1: input register.
  logic                   v1_r;
  logic signed [IN_W-1:0] w_r, x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    w_r <= in_quat_w;
    x_r <= in_quat_x;
    y_r <= in_quat_y;
    z_r <= in_quat_z;
  end

  // Stage 2: the ten pairwise products.
  logic                     v2_r;
  logic signed [PROD_W-1:0] ww_r, xx_r, yy_r, zz_r, wx_r, wy_r, wz_r, xy_r, xz_r, yz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    ww_r <= w_r * w_r;
    xx_r <= x_r * x_r;
    yy_r <= y_r * y_r;
    zz_r <= z_r * z_r;
    wx_r <= w_r * x_r;
    wy_r <= w_r * y_r;
    wz_r <= w_r * z_r;
    xy_r <= x_r * y_r;
    xz_r <= x_r * z_r;
    yz_r <= y_r * z_r;
  end

  // Stage 3: the atan2 operands and the pitch sine term.
  logic  v3_r;
  side_t s3_r;

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    return {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    s3_r.roll_y <= (ext(yz_r) + ext(wx_r)) <<< 1;
    s3_r.roll_x <= ext(ww_r) - ext(xx_r) - ext(yy_r) + ext(zz_r);
    s3_r.yaw_y  <= (ext(xy_r) + ext(wz_r)) <<< 1;
    s3_r.yaw_x  <= ext(ww_r) + ext(xx_r) - ext(yy_r) - ext(zz_r);
    s3_r.sin_p  <= (ext(xz_r) - ext(wy_r)) <<< 1;
  end

  // Stage 4: clamp decision and magnitude of the sine term.
  logic                    v4_r;
  logic [ROOT_W-1:0]       sin_abs_r;
  logic signed [SUM_W-1:0] sin_neg;

  assign sin_neg = -s3_r.sin_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    sin_abs_r <= s3_r.sin_p[SUM_W-1] ? sin_neg[ROOT_W-1:0] : s3_r.sin_p[ROOT_W-1:0];
  end

  // Side data rides along with the square root stages.
  side_t  side_r  [0:SIDE_LEN-1];
  clamp_t sclmp_r [0:SIDE_LEN-1];

  always_ff @(posedge clk) begin
    side_r[0]            <= s3_r;
    sclmp_r[0].clamp_pos <= s3_r.sin_p > UNIT_Q28;
    sclmp_r[0].clamp_neg <= s3_r.sin_p < -UNIT_Q28;
    for (int j = 1; j < SIDE_LEN; j++) begin
      side_r[j]  <= side_r[j-1];
      sclmp_r[j] <= sclmp_r[j-1];
    end
  end

  // Cosine squared = 1 - sine squared, fed to the square root.
  logic [2*ROOT_W-1:0] sin_sq;
  logic [2*ROOT_W-1:0] radicand_full;

  assign sin_sq        = sin_abs_r * sin_abs_r;
  assign radicand_full = ((2 * ROOT_W)'(1) << (2 * (ROOT_W - 1))) - sin_sq;

  logic              sqrt_valid;
  logic [ROOT_W-1:0] cos_root;

  qte_sqrt u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v4_r),
    .in_radicand (radicand_full[RAD_W-1:0]),
    .out_valid   (sqrt_valid),
    .out_root    (cos_root)
  );

  // Three angle units side by side.
  side_t                      sd;
  logic signed [CORDIC_W-1:0] roll_x_c, roll_y_c, yaw_x_c, yaw_y_c, pit_x_c, pit_y_c;

  assign sd       = side_r[SIDE_LEN-1];
  assign roll_x_c = {{(CORDIC_W - SUM_W){sd.roll_x[SUM_W-1]}}, sd.roll_x};
  assign roll_y_c = {{(CORDIC_W - SUM_W){sd.roll_y[SUM_W-1]}}, sd.roll_y};
  assign yaw_x_c  = {{(CORDIC_W - SUM_W){sd.yaw_x[SUM_W-1]}}, sd.yaw_x};
  assign yaw_y_c  = {{(CORDIC_W - SUM_W){sd.yaw_y[SUM_W-1]}}, sd.yaw_y};
  assign pit_x_c  = $signed({{(CORDIC_W - ROOT_W){1'b0}}, cos_root});
  assign pit_y_c  = {{(CORDIC_W - SUM_W){sd.sin_p[SUM_W-1]}}, sd.sin_p};

  logic             roll_v, pitch_v, yaw_v;
  logic [ANG_W-1:0] roll_ang, pitch_ang, yaw_ang;

  qte_cordic #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_roll (
    .clk(clk), .rst_n(rst_n), .in_valid(sqrt_valid), .in_x(roll_x_c), .in_y(roll_y_c),
    .out_valid(roll_v), .out_angle(roll_ang)
  );

  qte_cordic #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_pitch (
    .clk(clk), .rst_n(rst_n), .in_valid(sqrt_valid), .in_x(pit_x_c), .in_y(pit_y_c),
    .out_valid(pitch_v), .out_angle(pitch_ang)
  );

  qte_cordic #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_yaw (
    .clk(clk), .rst_n(rst_n), .in_valid(sqrt_valid), .in_x(yaw_x_c), .in_y(yaw_y_c),
    .out_valid(yaw_v), .out_angle(yaw_ang)
  );

  // Clamp flags follow the angle units.
  clamp_t cclmp_r [0:ANGLE_ITERATIONS];

  always_ff @(posedge clk) begin
    cclmp_r[0] <= sclmp_r[SIDE_LEN-1];
    for (int j = 1; j <= ANGLE_ITERATIONS; j++) begin
      cclmp_r[j] <= cclmp_r[j-1];
    end
  end

  // Output stage: pitch select and round half up to 16 bits.
  clamp_t           cl;
  logic [ANG_W-1:0] pitch_sel;
  logic [ANG_W-1:0] roll_rnd, pitch_rnd, yaw_rnd;

  assign cl = cclmp_r[ANGLE_ITERATIONS];

  always_comb begin
    if (cl.clamp_pos) begin
      pitch_sel = -QUARTER_TURN;
    end else if (cl.clamp_neg) begin
      pitch_sel = QUARTER_TURN;
    end else begin
      pitch_sel = -pitch_ang;
    end
  end

  assign roll_rnd  = roll_ang + ROUND_HALF;
  assign pitch_rnd = pitch_sel + ROUND_HALF;
  assign yaw_rnd   = yaw_ang + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= roll_v;
    end
    out_roll_angle    <= $signed(roll_rnd[ANG_W-1 -: OUT_W]);
    out_pitch_angle   <= $signed(pitch_rnd[ANG_W-1 -: OUT_W]);
    out_yaw_angle     <= $signed(yaw_rnd[ANG_W-1 -: OUT_W]);
    out_pitch_clamped <= cl.clamp_pos || cl.clamp_neg;
  end

  // Checks.
  a_units_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (roll_v == pitch_v) && (roll_v == yaw_v))
    else $error("angle unit valid bits disagree");

  a_clamp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    roll_v |-> !(cl.clamp_pos && cl.clamp_neg))
    else $error("pitch clamped in both directions");

  a_clamp_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pitch_clamped) |->
      (out_pitch_angle == 16'sd16384 || out_pitch_angle == -16'sd16384))
    else $error("clamped pitch is not a quarter turn");

endmodule

`default_nettype wire
